@@ hw/rtl/normal_tilt_angle_quantizer_macros.svh @@
// ============================================================================
// Assertion macros for the tilt angle quantizer
// Shared property forms, clocked on clk and disabled while rst_n is low.
// ============================================================================
`ifndef NORMAL_TILT_ANGLE_QUANTIZER_MACROS_SVH
`define NORMAL_TILT_ANGLE_QUANTIZER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NTAQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define NTAQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/ntaq_pkg.sv @@
// ============================================================================
// ntaq_pkg
// Widths, constant tables and datapath types of the tilt angle quantizer.
// ============================================================================
package ntaq_pkg;

    // Component width and CORDIC depth.
    localparam int COMPONENT_BITS   = 16;
    localparam int ANGLE_ITERATIONS = 12;
    localparam int ITER_COUNT       = (ANGLE_ITERATIONS > 24) ? 24 :
                                      ((ANGLE_ITERATIONS < 1) ? 1 : ANGLE_ITERATIONS);

    // Datapath formats: magnitudes are left aligned so all values stay below 2^50.
    localparam int MAG_BITS    = COMPONENT_BITS + 1;
    localparam int WORK_SHIFT  = 48 - COMPONENT_BITS;
    localparam int WORK_BITS   = 52;
    localparam int GAIN_BITS   = 17;
    localparam int GAIN_FRAC   = 16;
    localparam int PROD_BITS   = MAG_BITS + GAIN_BITS;
    localparam int ANGLE_FRAC  = 30;
    localparam int ANGLE_BITS  = ANGLE_FRAC + 4;
    localparam int TABLE_DEPTH = 24;
    localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
    localparam int CODE_BITS   = 8;
    localparam int SCALE_BITS  = ANGLE_BITS - 1 + CODE_BITS;
    localparam int QUOT_BITS   = SCALE_BITS - ANGLE_FRAC;
    localparam logic [CODE_BITS-1:0] CODE_MAX = {CODE_BITS{1'b1}};

    // Arctangent of 2^-i, pi/2 = 2^30.
    localparam logic signed [ANGLE_BITS-1:0] ATAN_TABLE [TABLE_DEPTH] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    // CORDIC gain after n iterations (entry n-1), Q16.
    localparam logic [GAIN_BITS-1:0] GAIN_TABLE [TABLE_DEPTH] = '{
        92682, 103621, 106811, 107642, 107852, 107905,
        107918, 107921, 107921, 107921, 107921, 107921,
        107921, 107921, 107921, 107921, 107921, 107921,
        107921, 107921, 107921, 107921, 107921, 107921
    };
    localparam logic [GAIN_BITS-1:0] GAIN = GAIN_TABLE[ITER_COUNT-1];

    // Per-item flags and the gain-scaled vertical component.
    typedef struct packed {
        logic                        zero;
        logic                        horiz;
        logic                        vert;
        logic signed [WORK_BITS-1:0] zk;
    } side_t;

    // One beat inside a CORDIC pipeline.
    typedef struct packed {
        logic signed [WORK_BITS-1:0]  x;
        logic signed [WORK_BITS-1:0]  y;
        logic signed [ANGLE_BITS-1:0] ang;
        side_t                        side;
    } cordic_t;

    // One vectoring micro-rotation: drives y toward zero.
    function automatic cordic_t cordic_step(cordic_t b, logic [IDX_BITS-1:0] idx);
        cordic_t                     r;
        logic signed [WORK_BITS-1:0] dx;
        logic signed [WORK_BITS-1:0] dy;
        r  = b;
        dx = b.y >>> idx;
        dy = b.x >>> idx;
        if (b.y > 0)
        begin
            r.x   = b.x + dx;
            r.y   = b.y - dy;
            r.ang = b.ang + ATAN_TABLE[idx];
        end
        else
        begin
            r.x   = b.x - dx;
            r.y   = b.y + dy;
            r.ang = b.ang - ATAN_TABLE[idx];
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/ntaq_cordic.sv @@
// ============================================================================
// ntaq_cordic
// Vectoring CORDIC, one micro-rotation per register stage, shared stall.
// ============================================================================
module ntaq_cordic (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              in_valid,
    input  ntaq_pkg::cordic_t in_beat,
    output logic              out_valid,
    output ntaq_pkg::cordic_t out_beat
);

    ntaq_pkg::cordic_t                   beat_reg  [ntaq_pkg::ITER_COUNT];
    ntaq_pkg::cordic_t                   beat_next [ntaq_pkg::ITER_COUNT];
    logic [ntaq_pkg::ITER_COUNT-1:0]     valid_reg;

    for (genvar i = 0; i < ntaq_pkg::ITER_COUNT; i++)
    begin : g_stage
        // Rotation i works on the previous stage, or on the input beat.
        if (i == 0)
        begin : g_first
            assign beat_next[i] = ntaq_pkg::cordic_step(in_beat,
                                                        ntaq_pkg::IDX_BITS'(i));
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    valid_reg[i] <= 1'b0;
                else if (adv)
                    valid_reg[i] <= in_valid;
            end
        end
        else
        begin : g_rest
            assign beat_next[i] = ntaq_pkg::cordic_step(beat_reg[i-1],
                                                        ntaq_pkg::IDX_BITS'(i));
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    valid_reg[i] <= 1'b0;
                else if (adv)
                    valid_reg[i] <= valid_reg[i-1];
            end
        end

        // Payload moves with the valid bit and holds during a stall.
        always_ff @(posedge clk)
        begin
            if (adv)
                beat_reg[i] <= beat_next[i];
        end
    end

    assign out_valid = valid_reg[ntaq_pkg::ITER_COUNT-1];
    assign out_beat  = beat_reg[ntaq_pkg::ITER_COUNT-1];

endmodule

@@ hw/rtl/normal_tilt_angle_quantizer.sv @@
// ============================================================================
// normal_tilt_angle_quantizer
// Tilt of a surface normal from vertical, scaled so pi/2 maps to 255.
// ============================================================================
//
//  Channel   Dir  tdata                          tuser
//  s_axis    in   [15:0] x, [31:16] y, [47:32] z  -
//  m_axis    out  [7:0] tilt_code                 [0] zero_normal
//
//  One beat is accepted per cycle while s_axis_tready is high; a result passes
//  through the input register, scaling stage, two 12-stage CORDIC pipelines,
//  a code stage and the output register.
//  rst_n clears all valid bits asynchronously; payload registers are not reset.
//  A skid register behind the output takes one more result while the output
//  waits; s_axis_tready drops only while that skid register is full.
// ============================================================================
module normal_tilt_angle_quantizer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // [15:0] normal_x, [31:16] normal_y, [47:32] normal_z
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] tilt_code
    output logic        m_axis_tuser    // [0] zero_normal
);

    localparam int CB = ntaq_pkg::COMPONENT_BITS;

    // Whole pipeline advances while the skid register is free.
    logic adv;

    logic                                 s1_valid_reg;
    logic [ntaq_pkg::MAG_BITS-1:0]        mag_x_reg;
    logic [ntaq_pkg::MAG_BITS-1:0]        mag_y_reg;
    logic [ntaq_pkg::MAG_BITS-1:0]        mag_z_reg;
    logic [ntaq_pkg::MAG_BITS-1:0]        mag_x_next;
    logic [ntaq_pkg::MAG_BITS-1:0]        mag_y_next;
    logic [ntaq_pkg::MAG_BITS-1:0]        mag_z_next;

    logic                                 s2_valid_reg;
    ntaq_pkg::cordic_t                    s2_reg;
    ntaq_pkg::cordic_t                    s2_next;
    logic [ntaq_pkg::PROD_BITS-1:0]       zk_prod;

    logic                                 c1_valid;
    ntaq_pkg::cordic_t                    c1_beat;
    ntaq_pkg::cordic_t                    c2_in;
    logic                                 c2_valid;
    ntaq_pkg::cordic_t                    c2_beat;

    logic                                 code_valid_reg;
    logic [ntaq_pkg::CODE_BITS-1:0]       code_reg;
    logic                                 zero_reg;
    logic [ntaq_pkg::CODE_BITS-1:0]       code_next;
    logic [ntaq_pkg::ANGLE_BITS-2:0]      ang_mag;
    logic [ntaq_pkg::SCALE_BITS-1:0]      ang_scaled;
    logic [ntaq_pkg::QUOT_BITS-1:0]       ang_quot;

    logic                                 out_valid_reg;
    logic [ntaq_pkg::CODE_BITS-1:0]       out_code_reg;
    logic                                 out_zero_reg;
    logic                                 skid_valid_reg;
    logic [ntaq_pkg::CODE_BITS-1:0]       skid_code_reg;
    logic                                 skid_zero_reg;
    logic                                 out_take;

    assign adv           = !skid_valid_reg;
    assign s_axis_tready = adv;

    // Magnitudes of the three two's complement components.
    function automatic logic [ntaq_pkg::MAG_BITS-1:0] comp_mag(logic [CB-1:0] v);
        logic signed [ntaq_pkg::MAG_BITS-1:0] s;
        s = $signed({v[CB-1], v});
        return s[ntaq_pkg::MAG_BITS-1] ? ntaq_pkg::MAG_BITS'(-s) : ntaq_pkg::MAG_BITS'(s);
    endfunction

    assign mag_x_next = comp_mag(s_axis_tdata[CB-1:0]);
    assign mag_y_next = comp_mag(s_axis_tdata[2*CB-1:CB]);
    assign mag_z_next = comp_mag(s_axis_tdata[3*CB-1:2*CB]);

    // Stage 1: register input magnitudes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (adv)
            s1_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mag_x_reg <= mag_x_next;
            mag_y_reg <= mag_y_next;
            mag_z_reg <= mag_z_next;
        end
    end

    // Stage 2: align to the work format, scale |z| by the CORDIC gain, flag cases.
    assign zk_prod = ntaq_pkg::PROD_BITS'(mag_z_reg) * ntaq_pkg::PROD_BITS'(ntaq_pkg::GAIN);

    always_comb
    begin
        s2_next.x          = $signed(ntaq_pkg::WORK_BITS'(mag_x_reg) << ntaq_pkg::WORK_SHIFT);
        s2_next.y          = $signed(ntaq_pkg::WORK_BITS'(mag_y_reg) << ntaq_pkg::WORK_SHIFT);
        s2_next.ang        = '0;
        s2_next.side.zero  = (mag_x_reg == '0) && (mag_y_reg == '0) && (mag_z_reg == '0);
        s2_next.side.horiz = (mag_z_reg == '0);
        s2_next.side.vert  = (mag_x_reg == '0) && (mag_y_reg == '0);
        s2_next.side.zk    = $signed(ntaq_pkg::WORK_BITS'(zk_prod)
                                     << (ntaq_pkg::WORK_SHIFT - ntaq_pkg::GAIN_FRAC));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (adv)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            s2_reg <= s2_next;
    end

    // First CORDIC: horizontal magnitude times the gain.
    ntaq_cordic u_cordic_mag (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s2_valid_reg),
        .in_beat   (s2_reg),
        .out_valid (c1_valid),
        .out_beat  (c1_beat)
    );

    // Second CORDIC: angle of (gain * |z|, gain * horizontal magnitude).
    always_comb
    begin
        c2_in      = c1_beat;
        c2_in.x    = c1_beat.side.zk;
        c2_in.y    = c1_beat.x;
        c2_in.ang  = '0;
    end

    ntaq_cordic u_cordic_ang (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (c1_valid),
        .in_beat   (c2_in),
        .out_valid (c2_valid),
        .out_beat  (c2_beat)
    );

    // Code stage: angle * 255 / 2^30, clamped, with the special cases on top.
    assign ang_mag    = c2_beat.ang[ntaq_pkg::ANGLE_BITS-2:0];
    assign ang_scaled = {ang_mag, {ntaq_pkg::CODE_BITS{1'b0}}}
                        - ntaq_pkg::SCALE_BITS'(ang_mag);
    assign ang_quot   = ang_scaled[ntaq_pkg::SCALE_BITS-1:ntaq_pkg::ANGLE_FRAC];

    always_comb
    begin
        priority if (c2_beat.side.horiz)
            code_next = ntaq_pkg::CODE_MAX;
        else if (c2_beat.side.vert)
            code_next = '0;
        else if (c2_beat.ang <= 0)
            code_next = '0;
        else if (ang_quot > ntaq_pkg::QUOT_BITS'(ntaq_pkg::CODE_MAX))
            code_next = ntaq_pkg::CODE_MAX;
        else
            code_next = ang_quot[ntaq_pkg::CODE_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            code_valid_reg <= 1'b0;
        else if (adv)
            code_valid_reg <= c2_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            code_reg <= code_next;
            zero_reg <= c2_beat.side.zero;
        end
    end

    // Output register with a skid register behind it.
    assign out_take = out_valid_reg && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
                skid_valid_reg <= 1'b0;
        end
        else if (code_valid_reg)
        begin
            if (out_valid_reg && !m_axis_tready)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_code_reg <= skid_code_reg;
                out_zero_reg <= skid_zero_reg;
            end
        end
        else if (code_valid_reg)
        begin
            if (out_valid_reg && !m_axis_tready)
            begin
                skid_code_reg <= code_reg;
                skid_zero_reg <= zero_reg;
            end
            else
            begin
                out_code_reg <= code_reg;
                out_zero_reg <= zero_reg;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_code_reg;
    assign m_axis_tuser  = out_zero_reg;

endmodule

@@ hw/rtl/ntaq_checker.sv @@
// ============================================================================
// ntaq_checker
// Port-level checks of the tilt angle quantizer, bound to the top level.
// ============================================================================
`include "normal_tilt_angle_quantizer_macros.svh"

module ntaq_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic        m_axis_tuser
);

    // A zero normal always reports the horizontal code.
    `NTAQ_ASSERT_NOW(a_zero_code, m_axis_tvalid && m_axis_tuser, m_axis_tdata == 8'hFF, "zero normal without code 255")

    // Input back-pressure only while a result is being offered.
    `NTAQ_ASSERT_NOW(a_stall_cause, !s_axis_tready, m_axis_tvalid, "input stalled with empty output")

    // With the output stalled, a full skid register stays full.
    `NTAQ_ASSERT_NEXT(a_stall_holds, !s_axis_tready && !m_axis_tready, !s_axis_tready, "skid drained without an output beat")

    // A stalled output beat holds its payload.
    `NTAQ_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled output beat changed")

endmodule

bind normal_tilt_angle_quantizer ntaq_checker u_ntaq_checker (.*);
